// ----- hw/rtl/hbd_pkg.sv -----
// shared types, constants and helpers for the http body deframer
package hbd_pkg;

	localparam int CNT_W = 32;
	localparam int REG_W = 32;
	localparam int BYTE_W = 8;

	localparam logic [2:0] PH_HEX = 3'd0;
	localparam logic [2:0] PH_EXT = 3'd1;
	localparam logic [2:0] PH_CR = 3'd2;
	localparam logic [2:0] PH_DATA = 3'd3;
	localparam logic [2:0] PH_TRAIL1 = 3'd4;
	localparam logic [2:0] PH_TRAIL2 = 3'd5;

	localparam logic [1:0] ST_BUSY = 2'd0;
	localparam logic [1:0] ST_DONE = 2'd1;
	localparam logic [1:0] ST_BIG = 2'd2;

	localparam logic [1:0] REG_CHUNKED = 2'd0;
	localparam logic [1:0] REG_CLEN = 2'd1;
	localparam logic [1:0] REG_MAXBODY = 2'd2;

	localparam logic [BYTE_W-1:0] CH_CR = 8'h0d;
	localparam logic [BYTE_W-1:0] CH_LF = 8'h0a;

	typedef struct packed {
		logic chunked_mode;
		logic [REG_W-1:0] body_len;
		logic [REG_W-1:0] size_limit;
	} cfg_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic is_payload;
		logic [1:0] status;
	} res_t;

	// bit 4 flags a hex digit, low nibble is its value
	function automatic logic [4:0] hex_digit(input logic [BYTE_W-1:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

endpackage

// ----- hw/rtl/http_body_deframer_top.sv -----
// top level of the http body deframer
//
//  channel  dir  handshake                     payload
//  s_axis   in   s_axis_tvalid/s_axis_tready   tdata[7:0] in_byte
//  m_axis   out  m_axis_tvalid/m_axis_tready   tdata out_byte, status; tuser is_payload
//  cfg      in   cfg_valid/cfg_ready           cfg_index, cfg_data
//
//  one byte per cycle while m_axis_tready allows; a result passes the input register and then
//  the result register, with the decode logic between them, before it is offered
//  arst_n clears the framing state, the configuration registers and both valid flags
//  a stalled output holds its result; the input register keeps filling until both are full
module http_body_deframer_top import hbd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [7:0] s_axis_tdata, // [7:0] in_byte
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [15:0] m_axis_tdata, // [7:0] out_byte, [9:8] status, rest zero
	output logic m_axis_tuser, // [0] is_payload
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [REG_W-1:0] cfg_data
);

	cfg_t cfg;
	res_t res, res_out;
	logic valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic out_full;
	logic adv;
	logic take;

	assign cfg_ready = 1'b1;
	assign take = out_full && m_axis_tready;
	assign adv = valid_s1 && (!out_full || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	hbd_cfg_regs u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(cfg_valid && cfg_ready),
		.wr_index(cfg_index),
		.wr_data(cfg_data),
		.cfg(cfg)
	);

	hbd_parse u_parse (
		.clk(clk),
		.arst_n(arst_n),
		.step(adv),
		.byte_in(byte_s1),
		.cfg(cfg),
		.res(res)
	);

	hbd_out_reg u_out (
		.clk(clk),
		.arst_n(arst_n),
		.load(adv),
		.res(res),
		.take(take),
		.full(out_full),
		.res_out(res_out)
	);

	assign m_axis_tvalid = out_full;
	assign m_axis_tdata = {6'd0, res_out.status, res_out.out_byte};
	assign m_axis_tuser = res_out.is_payload;

endmodule

// ----- hw/rtl/hbd_cfg_regs.sv -----
// configuration register file of the http body deframer
module hbd_cfg_regs import hbd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  logic [1:0] wr_index,
	input  logic [REG_W-1:0] wr_data,
	output cfg_t cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.chunked_mode <= 1'b0;
			cfg_q.body_len <= '0;
			cfg_q.size_limit <= '1;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_CHUNKED: cfg_q.chunked_mode <= wr_data[0];
				REG_CLEN: cfg_q.body_len <= wr_data;
				REG_MAXBODY: cfg_q.size_limit <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- hw/rtl/hbd_parse.sv -----
// framing state and per-byte decode of the http body deframer
module hbd_parse import hbd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  logic [BYTE_W-1:0] byte_in,
	input  cfg_t cfg,
	output res_t res
);

	logic [2:0] phase_q, n_phase;
	logic [CNT_W-1:0] rem_q, n_rem;
	logic [CNT_W-1:0] cnt_q, n_cnt;
	logic [1:0] fin_q, n_fin;
	logic pay;

	logic [CNT_W-1:0] cnt_inc;
	logic [CNT_W-1:0] clen;
	logic [CNT_W-1:0] maxb;
	logic [CNT_W-1:0] room;
	logic [4:0] hd;
	logic is_cr;

	assign clen = CNT_W'(cfg.body_len);
	assign maxb = CNT_W'(cfg.size_limit);
	assign cnt_inc = (cnt_q != '1) ? cnt_q + 1'b1 : cnt_q;
	assign room = maxb - rem_q;
	assign hd = hex_digit(byte_in);
	assign is_cr = (byte_in == CH_CR);

	always_comb begin
		n_phase = phase_q;
		n_rem = rem_q;
		n_cnt = cnt_q;
		n_fin = fin_q;
		pay = 1'b0;
		if (fin_q != ST_BUSY) begin
			// body ended, drop
		end else if (!cfg.chunked_mode) begin
			if (cnt_q >= clen) begin
				n_fin = ST_DONE;
			end else begin
				pay = 1'b1;
				n_cnt = cnt_inc;
				if (cnt_inc >= clen) begin
					n_fin = ST_DONE;
				end
			end
		end else begin
			unique case (phase_q)
				PH_DATA: begin
					pay = 1'b1;
					n_cnt = cnt_inc;
					n_rem = (rem_q != '0) ? rem_q - 1'b1 : rem_q;
					if (rem_q <= CNT_W'(1)) begin
						n_phase = PH_TRAIL1;
					end
				end
				PH_TRAIL1: n_phase = PH_TRAIL2;
				PH_TRAIL2: begin
					n_phase = PH_HEX;
					n_rem = '0;
				end
				PH_CR: begin
					if (byte_in == CH_LF) begin
						if (rem_q > maxb || cnt_q > room) begin
							n_fin = ST_BIG;
						end else if (rem_q == '0) begin
							n_fin = ST_DONE;
						end else begin
							n_phase = PH_DATA;
						end
					end else begin
						n_phase = is_cr ? PH_CR : PH_EXT;
					end
				end
				PH_HEX, PH_EXT: begin
					if (is_cr) begin
						n_phase = PH_CR;
					end else if (phase_q != PH_HEX || !hd[4]) begin
						n_phase = PH_EXT;
					end else if (rem_q[CNT_W-1 -: 4] != 4'd0) begin
						n_rem = '1;
					end else begin
						n_rem = {rem_q[CNT_W-5:0], hd[3:0]};
					end
				end
				default: begin
					n_phase = PH_HEX;
					n_rem = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEX;
			rem_q <= '0;
			cnt_q <= '0;
			fin_q <= ST_BUSY;
		end else if (step) begin
			phase_q <= n_phase;
			rem_q <= n_rem;
			cnt_q <= n_cnt;
			fin_q <= n_fin;
		end
	end

	assign res.out_byte = pay ? byte_in : '0;
	assign res.is_payload = pay;
	assign res.status = n_fin;

	// an ended body stays ended
	a_fin_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q != ST_BUSY |=> fin_q == $past(fin_q))
		else $error("final status changed after body end");

	// data phase always has bytes left
	a_data_rem: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> rem_q != '0)
		else $error("data phase with empty chunk");

	// a taken payload byte advances the body count unless saturated
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		step && pay && cnt_q != '1 |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("body count did not advance on payload");

endmodule

// ----- hw/rtl/hbd_out_reg.sv -----
// result register of the http body deframer
module hbd_out_reg import hbd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  res_t res,
	input  logic take,
	output logic full,
	output res_t res_out
);

	logic full_q;
	res_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (load) begin
			full_q <= 1'b1;
		end else if (take) begin
			full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign full = full_q;
	assign res_out = res_q;

	// a held result is never overwritten before it is taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		full_q && !take |-> !load)
		else $error("result overwritten while stalled");

endmodule
